// ===== rtl/rcf_pkg.sv =====
// Shared constants and types for the 3x3 RGB convolution filter.
package rcf_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Register and payload widths
    localparam int CFG_W   = 12;
    localparam int ROW_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int CIDX_W  = 2;
    localparam int MODE_W  = 2;

    // Width used to compare the column counter against the line length
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

    // Divide by nine: floor(sum * 7282 / 2^16) is exact for sums up to 9 * 255
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int BLUR_SHIFT  = 16;
    localparam logic [RECIP_W-1:0] BLUR_RECIP = 13'd7282;

    // Signed accumulator for edge and sharpen kernels
    localparam int ACC_W = 13;

    typedef enum logic [MODE_W-1:0] {
        MODE_EDGE    = 2'd0,
        MODE_BLUR    = 2'd1,
        MODE_SHARPEN = 2'd2
    } t_filter_mode;

endpackage

// ===== rtl/rcf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rgb_conv3x3_filter.sv =====
// Top level of the 3x3 RGB convolution filter with two line stores.
// A window's last pixel is registered in the input stage, its result in the output stage.
// Throughput: one pixel per cycle unless stalled; stores read on accept, write on advance.
// The input stalls only while a held result blocks an interior result in the input register.
// Reset (synchronous, active low) clears the registers to their defaults, the
// counters, the window and the valid flags; line stores are not cleared.
module rgb_conv3x3_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [rcf_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [rcf_pkg::CFG_W-1:0]   i_cfg_data,
    // Pixel input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rcf_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [rcf_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [rcf_pkg::CHAN_W-1:0]  i_blue_in,
    // Result output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rcf_pkg::CHAN_W-1:0]  o_red_out,
    output logic [rcf_pkg::CHAN_W-1:0]  o_green_out,
    output logic [rcf_pkg::CHAN_W-1:0]  o_blue_out,
    output logic                        o_frame_done
);

    import rcf_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;

    // Raster position of the next pixel
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;

    // Input stage
    logic              r_a_valid;
    logic [PIX_W-1:0]  r_a_px;
    logic [COL_W-1:0]  r_a_col;
    logic              r_a_emit;
    logic              r_a_last;

    // Window: two previous columns, top/middle/bottom each
    logic [PIX_W-1:0]  r_win [6];

    // Output stage
    logic              r_b_valid;
    logic [CHAN_W-1:0] r_b_red;
    logic [CHAN_W-1:0] r_b_green;
    logic [CHAN_W-1:0] r_b_blue;
    logic              r_b_last;
    logic              n_b_valid;

    logic [PIX_W-1:0]  rd_upper;
    logic [PIX_W-1:0]  rd_lower;

    logic [CMP_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic              line_end;
    logic              frame_end;
    logic              in_accept;
    logic              b_free;
    logic              a_advance;
    logic [CHAN_W-1:0] res_red;
    logic [CHAN_W-1:0] res_green;
    logic [CHAN_W-1:0] res_blue;

    // Filter one channel of a 3x3 window; p0..p8 in row-major order from the top left
    function automatic logic [CHAN_W-1:0] filter_chan(
        input logic [CHAN_W-1:0] p0, input logic [CHAN_W-1:0] p1,
        input logic [CHAN_W-1:0] p2, input logic [CHAN_W-1:0] p3,
        input logic [CHAN_W-1:0] p4, input logic [CHAN_W-1:0] p5,
        input logic [CHAN_W-1:0] p6, input logic [CHAN_W-1:0] p7,
        input logic [CHAN_W-1:0] p8, input logic [MODE_W-1:0] mode
    );
        logic [SUM_W-1:0]           sum;
        logic [SUM_W+RECIP_W-1:0]   prod;
        logic signed [ACC_W-1:0]    acc;
        logic [CHAN_W-1:0]          res;
        sum = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + SUM_W'(p3) + SUM_W'(p4)
            + SUM_W'(p5) + SUM_W'(p6) + SUM_W'(p7) + SUM_W'(p8);
        prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(BLUR_RECIP);
        acc  = '0;
        res  = '0;
        case (mode)
            MODE_EDGE: begin
                acc = $signed({{(ACC_W-CHAN_W-3){1'b0}}, p4, 3'b000})
                    + $signed(ACC_W'(p4)) - $signed(ACC_W'(sum));
            end
            MODE_SHARPEN: begin
                acc = $signed({{(ACC_W-CHAN_W-2){1'b0}}, p4, 2'b00})
                    + $signed(ACC_W'(p4)) - $signed(ACC_W'(p1)) - $signed(ACC_W'(p3))
                    - $signed(ACC_W'(p5)) - $signed(ACC_W'(p7));
            end
            default: begin
                acc = '0;
            end
        endcase
        // Clamp to the channel range; blur never leaves it
        if (mode == MODE_BLUR) begin
            res = prod[BLUR_SHIFT +: CHAN_W];
        end else if (acc < 0) begin
            res = '0;
        end else if (acc > $signed(ACC_W'({CHAN_W{1'b1}}))) begin
            res = '1;
        end else begin
            res = acc[CHAN_W-1:0];
        end
        return res;
    endfunction

    // Line stores: upper holds two lines back, lower one line back
    rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (a_advance),
        .i_waddr (r_a_col),
        .i_wdata (rd_lower),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (rd_upper)
    );

    rcf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (a_advance),
        .i_waddr (r_a_col),
        .i_wdata (r_a_px),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (rd_lower)
    );

    // Handshake: the input stage moves on when it has no result or the output can take one
    assign b_free    = !r_b_valid || !i_stall;
    assign a_advance = r_a_valid && (!r_a_emit || b_free);
    assign o_stall   = r_a_valid && !a_advance;
    assign in_accept = i_valid && !o_stall;

    // Saturate the frame geometry
    always_comb begin
        if (r_width < CFG_W'(3)) begin
            w_eff = CMP_W'(3);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = CMP_W'(r_width);
        end
        h_eff = (r_height < CFG_W'(3)) ? CFG_W'(3) : r_height;
    end

    assign line_end  = CMP_W'(r_col) >= (w_eff - CMP_W'(1));
    assign frame_end = line_end && (r_row >= ROW_W'(h_eff - CFG_W'(1)));

    // Advance the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (line_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_EDGE;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Counters and input stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_a_valid <= 1'b1;
            end else if (a_advance) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_px   <= {i_blue_in, i_green_in, i_red_in};
            r_a_col  <= r_col;
            r_a_emit <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_a_last <= frame_end;
        end
    end

    // Shift the window one column left as the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (a_advance) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= rd_upper;
            r_win[4] <= rd_lower;
            r_win[5] <= r_a_px;
        end
    end

    // Filter each channel over the full window
    always_comb begin
        res_red = filter_chan(
            r_win[0][0 +: CHAN_W], r_win[3][0 +: CHAN_W], rd_upper[0 +: CHAN_W],
            r_win[1][0 +: CHAN_W], r_win[4][0 +: CHAN_W], rd_lower[0 +: CHAN_W],
            r_win[2][0 +: CHAN_W], r_win[5][0 +: CHAN_W], r_a_px[0 +: CHAN_W], r_mode);
        res_green = filter_chan(
            r_win[0][CHAN_W +: CHAN_W], r_win[3][CHAN_W +: CHAN_W],
            rd_upper[CHAN_W +: CHAN_W],
            r_win[1][CHAN_W +: CHAN_W], r_win[4][CHAN_W +: CHAN_W],
            rd_lower[CHAN_W +: CHAN_W],
            r_win[2][CHAN_W +: CHAN_W], r_win[5][CHAN_W +: CHAN_W],
            r_a_px[CHAN_W +: CHAN_W], r_mode);
        res_blue = filter_chan(
            r_win[0][2*CHAN_W +: CHAN_W], r_win[3][2*CHAN_W +: CHAN_W],
            rd_upper[2*CHAN_W +: CHAN_W],
            r_win[1][2*CHAN_W +: CHAN_W], r_win[4][2*CHAN_W +: CHAN_W],
            rd_lower[2*CHAN_W +: CHAN_W],
            r_win[2][2*CHAN_W +: CHAN_W], r_win[5][2*CHAN_W +: CHAN_W],
            r_a_px[2*CHAN_W +: CHAN_W], r_mode);
    end

    // Output stage valid: load on a result, drop once taken
    always_comb begin
        if (a_advance && r_a_emit) begin
            n_b_valid = 1'b1;
        end else if (!i_stall) begin
            n_b_valid = 1'b0;
        end else begin
            n_b_valid = r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= n_b_valid;
        end
    end

    // Output stage payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (a_advance && r_a_emit) begin
            r_b_red   <= res_red;
            r_b_green <= res_green;
            r_b_blue  <= res_blue;
            r_b_last  <= r_a_last;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_red_out    = r_b_red;
    assign o_green_out  = r_b_green;
    assign o_blue_out   = r_b_blue;
    assign o_frame_done = r_b_last;

endmodule

// ===== verif/tb_rgb_conv3x3_filter.sv =====
// Testbench for the 3x3 RGB convolution filter: self-checking, with a built-in pixel predictor.
`timescale 1ns / 1ps

module tb_rgb_conv3x3_filter;
    import rcf_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_PIXELS = 850;
    localparam int WIDE_RUN      = 40;
    localparam int NARROW_RUN    = 30;

    // Unused selector value of the mode register
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Hand-picked 3-wide, 6-line frame; one interior result per line from the third on
    localparam logic [PIX_W-1:0] PROBE_FRAME [18] = '{
        24'h000000, 24'h000000, 24'h000000,
        24'h0000FF, 24'hFFFF00, 24'h0000FF,
        24'h00FF00, 24'h000000, 24'hFF00FF,
        24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
        24'h00FF00, 24'hFF0000, 24'h00FF00,
        24'h000000, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_done;
    } t_filtered;

    bit                 i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CIDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [CHAN_W-1:0]  i_red_in;
    logic [CHAN_W-1:0]  i_green_in;
    logic [CHAN_W-1:0]  i_blue_in;
    logic               o_valid;
    logic               i_stall;
    logic [CHAN_W-1:0]  o_red_out;
    logic [CHAN_W-1:0]  o_green_out;
    logic [CHAN_W-1:0]  o_blue_out;
    logic               o_frame_done;

    // Predictor copy of the registers and the pixel state
    logic [MODE_W-1:0]  cfg_mode;
    logic [CFG_W-1:0]   cfg_width;
    logic [CFG_W-1:0]   cfg_height;
    bit [PIX_W-1:0]     upper_line [MAX_WIDTH];
    bit [PIX_W-1:0]     lower_line [MAX_WIDTH];
    bit [PIX_W-1:0]     window_cols [6];
    int unsigned        line_col;
    int unsigned        line_row;

    t_filtered          filtered_q [$];
    int                 fail_count;
    int unsigned        pixels_sent;
    bit                 calm;
    int                 stall_left;

    rgb_conv3x3_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_done (o_frame_done)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Gap length: mostly none, some short, a few long; none at all in calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 24);
    endfunction

    // Channels lean toward the extremes now and then
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] px;
        int r;
        for (int k = 0; k < 3; k++) begin
            r = $urandom_range(0, 7);
            if (r == 0) begin
                px[8*k +: 8] = 8'h00;
            end else if (r == 1) begin
                px[8*k +: 8] = 8'hFF;
            end else begin
                px[8*k +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return px;
    endfunction

    // One channel of the 3x3 window, p[line*3 + column], clamped to 0..255
    function automatic logic [CHAN_W-1:0] kernel_channel(input bit [PIX_W-1:0] p [9],
                                                         input int k);
        int v [9];
        int sum;
        int acc;
        sum = 0;
        for (int i = 0; i < 9; i++) begin
            v[i] = p[i][8*k +: 8];
            sum += v[i];
        end
        case (cfg_mode)
            MODE_EDGE:    acc = 9 * v[4] - sum;
            MODE_BLUR:    acc = sum / 9;
            MODE_SHARPEN: acc = 5 * v[4] - v[1] - v[7] - v[3] - v[5];
            default:      acc = 0;
        endcase
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return CHAN_W'(acc);
    endfunction

    // Advance the predictor by one accepted pixel; queue a result for interior pixels
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        bit [PIX_W-1:0] up;
        bit [PIX_W-1:0] mid;
        bit [PIX_W-1:0] win9 [9];
        bit line_end;
        bit frame_end;
        t_filtered res;
        w = cfg_width;
        h = cfg_height;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 3) h = 3;
        idx = (line_col < MAX_WIDTH) ? line_col : MAX_WIDTH - 1;
        up  = upper_line[idx];
        mid = lower_line[idx];
        line_end  = line_col >= w - 1;
        frame_end = line_end && line_row >= h - 1;

        if (line_col >= 2 && line_row >= 2) begin
            win9 = '{window_cols[0], window_cols[3], up,
                     window_cols[1], window_cols[4], mid,
                     window_cols[2], window_cols[5], px};
            res.red        = kernel_channel(win9, 0);
            res.green      = kernel_channel(win9, 1);
            res.blue       = kernel_channel(win9, 2);
            res.frame_done = frame_end;
            filtered_q.push_back(res);
        end

        // shift the window left and bring in the new column
        window_cols[0] = window_cols[3];
        window_cols[1] = window_cols[4];
        window_cols[2] = window_cols[5];
        window_cols[3] = up;
        window_cols[4] = mid;
        window_cols[5] = px;
        upper_line[idx] = mid;
        lower_line[idx] = px;

        if (frame_end) begin
            line_col = 0;
            line_row = 0;
        end else if (line_end) begin
            line_col = 0;
            line_row = (line_row + 1) & 12'hFFF;
        end else begin
            line_col++;
        end
    endtask

    // Drive one pixel, hold it until accepted, then leave a random gap
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_red_in   <= px[7:0];
        i_green_in <= px[15:8];
        i_blue_in  <= px[23:16];
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_pixel(px);
        pixels_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Send random pixels until the frame counters wrap to the start
    task automatic send_to_frame_end();
        do begin
            send_pixel(random_pixel());
        end while (line_col != 0 || line_row != 0);
    endtask

    // Drop valid, wait for every expected result, then let border pixels flush
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_valid     <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (index)
            CFG_MODE:   cfg_mode   = value[MODE_W-1:0];
            CFG_WIDTH:  cfg_width  = value;
            CFG_HEIGHT: cfg_height = value;
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Narrowest frame, one interior result per mode, mode changed between results
    task automatic test_kernel_modes();
        cfg_write(CFG_MODE, CFG_W'(MODE_EDGE));
        cfg_write(CFG_WIDTH, 12'd3);
        cfg_write(CFG_HEIGHT, 12'd6);
        for (int i = 0; i < 9; i++) send_pixel(PROBE_FRAME[i]);
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_BLUR));
        for (int i = 9; i < 12; i++) send_pixel(PROBE_FRAME[i]);
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_SHARPEN));
        for (int i = 12; i < 15; i++) send_pixel(PROBE_FRAME[i]);
        wait_drained();
        // upper data bits set; the unused selector must give black
        cfg_write(CFG_MODE, {10'h3FF, MODE_UNUSED});
        for (int i = 15; i < 18; i++) send_pixel(PROBE_FRAME[i]);
    endtask

    // Cut a frame short mid-line by lowering height and width, then run a clean frame
    task automatic test_midframe_resize();
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_BLUR));
        cfg_write(CFG_WIDTH, 12'd12);
        cfg_write(CFG_HEIGHT, 12'd9);
        repeat (4 * 12 + 7) send_pixel(random_pixel());
        wait_drained();
        cfg_write(CFG_HEIGHT, 12'd3);
        cfg_write(CFG_WIDTH, 12'd5);
        send_to_frame_end();
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_EDGE));
        cfg_write(CFG_HEIGHT, 12'd4);
        send_to_frame_end();
    endtask

    // Out-of-range sizes: a first line past the store width with too few lines,
    // then the narrowest line over many lines; each cut short by a later resize
    task automatic test_line_extremes();
        calm = 1'b1;
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_SHARPEN));
        cfg_write(CFG_WIDTH, 12'hFFF);
        cfg_write(CFG_HEIGHT, 12'h000);
        repeat (WIDE_RUN) send_pixel(random_pixel());
        wait_drained();
        cfg_write(CFG_WIDTH, 12'd5);
        send_to_frame_end();
        wait_drained();
        cfg_write(CFG_MODE, CFG_W'(MODE_BLUR));
        cfg_write(CFG_WIDTH, 12'd1);
        cfg_write(CFG_HEIGHT, 12'hFFF);
        repeat (NARROW_RUN) send_pixel(random_pixel());
        wait_drained();
        cfg_write(CFG_HEIGHT, 12'd3);
        send_to_frame_end();
        calm = 1'b0;
    endtask

    // Random small frames, some interrupted by a register change at an idle point
    task automatic test_random_frames();
        int unsigned start_count;
        int unsigned w;
        int unsigned h;
        int unsigned cut;
        int r;
        start_count = pixels_sent;
        while (pixels_sent - start_count < RANDOM_PIXELS) begin
            calm = ($urandom_range(0, 6) == 0);
            wait_drained();
            r = $urandom_range(0, 29);
            if (r < 24) begin
                w = $urandom_range(3, 16);
                h = $urandom_range(3, 7);
            end else if (r < 28) begin
                w = $urandom_range(17, 64);
                h = $urandom_range(3, 4);
            end else begin
                w = $urandom_range(65, 256);
                h = 3;
            end
            if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2);
            cfg_write(CFG_MODE, CFG_W'($urandom));
            cfg_write(CFG_WIDTH, CFG_W'(w));
            cfg_write(CFG_HEIGHT, CFG_W'(h));

            if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, 3 * w - 1);
                repeat (cut) send_pixel(random_pixel());
                wait_drained();
                case ($urandom_range(0, 3))
                    0: cfg_write(CFG_MODE, CFG_W'($urandom));
                    1: cfg_write(CFG_HEIGHT, CFG_W'($urandom_range(0, 7)));
                    2: cfg_write(CFG_WIDTH, CFG_W'($urandom_range(3, w)));
                    default: ;
                endcase
            end
            send_to_frame_end();
        end
        calm = 1'b0;
    endtask

    // Receiver stalls of random length
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : check_result
        t_filtered want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (filtered_q.size() == 0) begin
                $error("result with none expected: red %0d green %0d blue %0d done %0d",
                       o_red_out, o_green_out, o_blue_out, o_frame_done);
                fail_count++;
            end else begin
                want = filtered_q.pop_front();
                check_field("red_out", want.red, o_red_out);
                check_field("green_out", want.green, o_green_out);
                check_field("blue_out", want.blue, o_blue_out);
                check_field("frame_done", CHAN_W'(want.frame_done), CHAN_W'(o_frame_done));
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_stall     = 1'b0;
        stall_left  = 0;
        calm        = 1'b0;
        fail_count  = 0;
        pixels_sent = 0;
        cfg_mode    = MODE_EDGE;
        cfg_width   = WIDTH_RST;
        cfg_height  = HEIGHT_RST;
        line_col    = 0;
        line_row    = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_kernel_modes();
        test_midframe_resize();
        test_line_extremes();
        test_random_frames();
        wait_drained();

        if (fail_count == 0) begin
            $display("tb_rgb_conv3x3_filter OK");
        end else begin
            $display("tb_rgb_conv3x3_filter NOT OK");
        end
        $finish;
    end

    // Hard stop well beyond the slowest passing run
    initial begin
        #20_000_000;
        $display("tb_rgb_conv3x3_filter NOT OK");
        $finish;
    end

endmodule

// ===== rgb_conv3x3_filter.f =====
rtl/rcf_pkg.sv
rtl/rcf_ram.sv
rtl/rgb_conv3x3_filter.sv
verif/tb_rgb_conv3x3_filter.sv
